/* src/ffpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

   // fixed field widths
   localparam int OPCODE_W   = 1;
   localparam int DATA_W     = 16;
   localparam int OFFSET_W   = 24;
   localparam int HEADER_W   = 10;
   localparam int KB_W       = 15;
   localparam int TOTAL_W    = 17;   // header + payload, at most 66558
   localparam int RSP_POOL_W = 25;
   localparam int KB_SHIFT   = 10;   // 1024 bytes per kilobyte

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_POOL_KB = 2'd1;

   localparam logic [HEADER_W-1:0] HEADER_RESET = 10'd128;
   localparam logic [KB_W-1:0]     KB_RESET     = 15'd1;

   // request opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_SPACE   = 2'd1,
      ST_TABLE_FULL = 2'd2
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_FREE,
      S_SCAN,
      S_SHIFT,
      S_GROW,
      S_DONE
   } fsm_state_type;

   // one free-table row
   typedef struct packed {
      logic [OFFSET_W-1:0] start;
      logic [TOTAL_W-1:0]  len;
   } free_entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request, clear result
      logic scan_init;   // rewind table walk
      logic walk_en;     // issue next table read
      logic hit_take;    // take fitting entry, split it
      logic shift_en;    // move read row one slot down
      logic shift_fin;   // drop emptied row from count
      logic free_push;   // append freed block
      logic grow_dbl;    // double pool size
      logic bump_alloc;  // allocate at bump end
      logic set_fail;    // flag out of space
   } ffpa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_free;     // captured request frees a block
      logic hit;         // row under test fits
      logic hit_zero;    // that row is used up by the request
      logic walk_done;   // walk passed the last valid row
      logic need_grow;   // bump allocation overruns the pool
      logic can_double;  // doubled pool stays within the maximum
   } ffpa_stat_type;

   function automatic logic [RSP_POOL_W-1:0] initial_pool(input logic [KB_W-1:0] kb);
      logic [KB_W-1:0] kb_eff;
      kb_eff = (kb == '0) ? KB_W'(1) : kb;
      return {kb_eff, {KB_SHIFT{1'b0}}};
   endfunction

endpackage

`default_nettype wire

/* src/ffpa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ctrl
   import ffpa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire ffpa_stat_type stat,
   output ffpa_cmd_type       cmd,
   output logic               busy,
   output logic               rsp_valid
);

   fsm_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_SCAN;
         end
         S_SCAN: begin
            // scan state also routes free requests out on its first cycle
            if (stat.is_free) begin
               state_in = S_FREE;
            end else if (stat.hit) begin
               state_in = stat.hit_zero ? S_SHIFT : S_DONE;
            end else if (stat.walk_done) begin
               state_in = S_GROW;
            end
         end
         S_FREE:  state_in = S_DONE;
         S_SHIFT: begin
            if (stat.walk_done) state_in = S_DONE;
         end
         S_GROW: begin
            if (!stat.need_grow || !stat.can_double) state_in = S_DONE;
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load      = 1'b1;
               cmd.scan_init = 1'b1;
            end
         end
         S_SCAN: begin
            if (!stat.is_free) begin
               cmd.walk_en  = 1'b1;
               cmd.hit_take = stat.hit;
            end
         end
         S_FREE: cmd.free_push = 1'b1;
         S_SHIFT: begin
            cmd.walk_en   = 1'b1;
            cmd.shift_en  = 1'b1;
            cmd.shift_fin = stat.walk_done;
         end
         S_GROW: begin
            if (!stat.need_grow) begin
               cmd.bump_alloc = 1'b1;
            end else if (stat.can_double) begin
               cmd.grow_dbl = 1'b1;
            end else begin
               cmd.set_fail = 1'b1;
            end
         end
         S_DONE:  rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

/* src/ffpa_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffpa_dpath
   import ffpa_pkg::*;
#(
   parameter int              FREE_SLOTS     = 16,
   parameter longint unsigned POOL_MAX_BYTES = 64'd16777216
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ffpa_cmd_type          cmd,
   output ffpa_stat_type              stat,
   input  wire logic [OPCODE_W-1:0]   req_opcode,
   input  wire logic [DATA_W-1:0]     req_data_bytes,
   input  wire logic [OFFSET_W-1:0]   req_entry_offset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic [1:0]                 rsp_status,
   output logic [OFFSET_W-1:0]        rsp_block_offset,
   output logic [RSP_POOL_W-1:0]      rsp_pool_bytes,
   output logic [RSP_POOL_W-1:0]      rsp_used_end
);

   localparam int MAX_BITS = $clog2(POOL_MAX_BYTES + 64'd1);
   localparam int POOL_W   = (MAX_BITS > RSP_POOL_W) ? MAX_BITS : RSP_POOL_W;
   localparam int CNT_W    = $clog2(FREE_SLOTS + 1);
   localparam int ADDR_W   = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam logic [POOL_W:0]  MAX_C  = (POOL_W + 1)'(POOL_MAX_BYTES);
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(FREE_SLOTS);

   // free table
   free_entry_type mem [FREE_SLOTS];

   // configuration and pool state
   logic [HEADER_W-1:0] hdr_ff;
   logic [POOL_W-1:0]   pool_ff, pool_in;
   logic [POOL_W-1:0]   end_ff, end_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // captured request
   logic                op_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [OFFSET_W-1:0] eoff_ff;

   // table walk
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0]   q_idx_ff;
   logic                q_vld_ff, q_vld_in;
   free_entry_type      q_ff;
   logic                rd_en;

   // result
   status_type          res_status_ff, res_status_in;
   logic [OFFSET_W-1:0] res_off_ff, res_off_in;

   // write port
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   free_entry_type      wr_data;

   logic [TOTAL_W-1:0]  remain;
   logic [POOL_W:0]     bump_end;
   logic                table_full;

   assign remain     = q_ff.len - total_ff;
   assign bump_end   = (POOL_W + 1)'(end_ff) + (POOL_W + 1)'(total_ff);
   assign table_full = (cnt_ff == SLOTS_C);
   assign rd_en      = cmd.walk_en && (rd_idx_ff < cnt_ff);

   // status to controller
   always_comb begin
      stat.is_free    = (op_ff == OP_FREE);
      stat.hit        = q_vld_ff && (q_ff.len >= total_ff);
      stat.hit_zero   = (remain == '0);
      stat.walk_done  = !q_vld_ff && (rd_idx_ff >= cnt_ff);
      stat.need_grow  = bump_end > (POOL_W + 1)'(pool_ff);
      stat.can_double = {pool_ff, 1'b0} <= MAX_C;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         total_ff <= TOTAL_W'(hdr_ff) + TOTAL_W'(req_data_bytes);
         eoff_ff  <= req_entry_offset;
      end
   end

   // walk pointer and read tracking
   always_comb begin
      rd_idx_in = rd_idx_ff;
      q_vld_in  = q_vld_ff;
      if (cmd.scan_init) begin
         rd_idx_in = '0;
         q_vld_in  = 1'b0;
      end else if (cmd.hit_take) begin
         rd_idx_in = CNT_W'(q_idx_ff) + CNT_W'(1);
         q_vld_in  = 1'b0;
      end else if (cmd.walk_en) begin
         q_vld_in = rd_en;
         if (rd_en) rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else begin
         q_vld_ff <= q_vld_in;
      end
      rd_idx_ff <= rd_idx_in;
   end

   // table write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = q_idx_ff;
      wr_data = q_ff;
      if (cmd.free_push) begin
         wr_en        = !table_full;
         wr_addr      = cnt_ff[ADDR_W-1:0];
         wr_data.start = eoff_ff;
         wr_data.len   = total_ff;
      end else if (cmd.hit_take) begin
         wr_en         = (remain != '0);
         wr_data.start = q_ff.start + OFFSET_W'(total_ff);
         wr_data.len   = remain;
      end else if (cmd.shift_en) begin
         wr_en   = q_vld_ff;
         wr_addr = q_idx_ff - ADDR_W'(1);
      end
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         q_ff     <= mem[rd_idx_ff[ADDR_W-1:0]];
         q_idx_ff <= rd_idx_ff[ADDR_W-1:0];
      end
   end

   // pool, bump end and table count
   always_comb begin
      pool_in = pool_ff;
      end_in  = end_ff;
      cnt_in  = cnt_ff;
      if (csr_we && (csr_index == CSR_INIT_POOL_KB)) begin
         pool_in = POOL_W'(initial_pool(csr_data[KB_W-1:0]));
      end
      if (cmd.grow_dbl)   pool_in = {pool_ff[POOL_W-2:0], 1'b0};
      if (cmd.bump_alloc) end_in  = bump_end[POOL_W-1:0];
      if (cmd.free_push && !table_full) cnt_in = cnt_ff + CNT_W'(1);
      if (cmd.shift_fin)  cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff  <= HEADER_RESET;
         pool_ff <= POOL_W'(initial_pool(KB_RESET));
         end_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         if (csr_we && (csr_index == CSR_HEADER_BYTES)) hdr_ff <= csr_data[HEADER_W-1:0];
         pool_ff <= pool_in;
         end_ff  <= end_in;
         cnt_ff  <= cnt_in;
      end
   end

   // result registers
   always_comb begin
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      if (cmd.load) begin
         res_status_in = ST_OK;
         res_off_in    = '0;
      end
      if (cmd.free_push && table_full) res_status_in = ST_TABLE_FULL;
      if (cmd.hit_take)   res_off_in    = q_ff.start;
      if (cmd.bump_alloc) res_off_in    = end_ff[OFFSET_W-1:0];
      if (cmd.set_fail)   res_status_in = ST_NO_SPACE;
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
   end

   assign rsp_status       = res_status_ff;
   assign rsp_block_offset = res_off_ff;
   assign rsp_pool_bytes   = pool_ff[RSP_POOL_W-1:0];
   assign rsp_used_end     = end_ff[RSP_POOL_W-1:0];

endmodule

`default_nettype wire

/* src/first_fit_pool_allocator.sv */
// Channel    Ports                                            Handshake
// request    req_opcode, req_data_bytes, req_entry_offset     start & !busy
// response   rsp_status, rsp_block_offset, rsp_pool_bytes,    rsp_valid, one cycle
//            rsp_used_end
// csr        csr_index, csr_data                              csr_valid & csr_ready
//
// Free request: the scan state routes it to the free state, which appends the
// block to the table, then the response follows.
// Allocate: free-table scan, one row per cycle through the table's single read
// port (the read pipe is filled first, then the end is seen after the last row);
// when a row is used up, later rows move down to close the gap; on a miss the pool
// doubles as needed, then the bump allocation or the failure, then the response.
// Synchronous active-high reset; the table holds no reset state.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_pool_allocator
   import ffpa_pkg::*;
#(
   parameter int              FREE_SLOTS     = 16,
   parameter longint unsigned POOL_MAX_BYTES = 64'd16777216
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [OPCODE_W-1:0]   req_opcode,
   input  wire logic [DATA_W-1:0]     req_data_bytes,
   input  wire logic [OFFSET_W-1:0]   req_entry_offset,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [OFFSET_W-1:0]        rsp_block_offset,
   output logic [RSP_POOL_W-1:0]      rsp_pool_bytes,
   output logic [RSP_POOL_W-1:0]      rsp_used_end,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   ffpa_cmd_type  cmd;
   ffpa_stat_type stat;
   logic          csr_we;

   // csr writes taken between requests
   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;

   ffpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ffpa_dpath #(
      .FREE_SLOTS     (FREE_SLOTS),
      .POOL_MAX_BYTES (POOL_MAX_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_data_bytes   (req_data_bytes),
      .req_entry_offset (req_entry_offset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset),
      .rsp_pool_bytes   (rsp_pool_bytes),
      .rsp_used_end     (rsp_used_end)
   );

endmodule

`default_nettype wire

/* src/ffpa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffpa_checker
   import ffpa_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 rsp_valid,
   input wire logic [1:0]           rsp_status,
   input wire logic [OFFSET_W-1:0]  rsp_block_offset,
   input wire logic                 csr_valid,
   input wire logic                 csr_ready
);

   // accepted request keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // response ends the request: single strobe, then idle
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response not followed by idle");

   // no response while idle
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response while idle");

   // failed requests report a zero offset, status codes stay legal
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK && rsp_status != 2'd3)
         || ((rsp_status == ST_NO_SPACE || rsp_status == ST_TABLE_FULL)
             && rsp_block_offset == '0))
      else $error("bad status or nonzero offset on failure");

   // csr port only open between requests
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !busy)
      else $error("csr write accepted during request");

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_block_offset (rsp_block_offset),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready)
);

`default_nettype wire
